// ----- design/swbt_pkg.sv -----
// Package for the sliding window band tracker.
// Holds field widths, the controller command struct and fixed-point helpers.
// No dependencies.
package swbt_pkg;

	localparam int unsigned MAX_WINDOW_DEF  = 64;
	localparam int unsigned SAMPLE_BITS_DEF = 32;

	localparam int unsigned DATA_W    = 32;
	localparam int unsigned SD_W      = 31;
	localparam int unsigned SQ_W      = 47;
	localparam int unsigned WLEN_W    = 7;
	localparam int unsigned GAIN_W    = 16;
	localparam int unsigned CFG_IDX_W = 1;
	localparam int unsigned CFG_DAT_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_BAND_GAIN     = 1'b1;

	localparam logic [WLEN_W-1:0] WLEN_RESET = 7'd20;
	localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd512;

	typedef struct packed {
		logic load_in;
		logic rd;
		logic sq;
		logic upd;
		logic dld;
		logic div;
		logic msq;
		logic sld;
		logic sqrt;
		logic spr;
		logic band;
	} swbt_cmd_t;

	function automatic logic [SQ_W-1:0] square_q16(input logic signed [DATA_W:0] v);
		logic [DATA_W-1:0] mag;
		logic [63:0]       prod;
		mag  = v[DATA_W] ? DATA_W'(-v) : v[DATA_W-1:0];
		prod = 64'(mag) * 64'(mag);
		return prod[62:16];
	endfunction

	function automatic logic signed [DATA_W-1:0] sat32(input logic signed [40:0] v);
		logic signed [40:0] hi;
		logic signed [40:0] lo;
		hi = 41'sh0_7FFF_FFFF;
		lo = -41'sh0_8000_0000;
		if (v > hi) begin
			return 32'sh7FFF_FFFF;
		end else if (v < lo) begin
			return 32'sh8000_0000;
		end
		return v[DATA_W-1:0];
	endfunction

endpackage

// ----- design/swbt_ctrl.sv -----
// Controller for the sliding window band tracker.
// Sequences the datapath through update, divide, square root and band steps.
// Depends on swbt_pkg.
module swbt_ctrl import swbt_pkg::*; #(
	parameter int unsigned MAX_WINDOW = MAX_WINDOW_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	output logic      out_valid,
	input  logic      out_stall,
	output swbt_cmd_t cmd
);

	localparam int unsigned DIV_W = SQ_W + $clog2(MAX_WINDOW);
	localparam int unsigned CNT_W = $clog2(DIV_W);
	localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(DIV_W - 1);
	localparam logic [CNT_W-1:0] SQRT_LAST = CNT_W'(31);

	typedef enum logic [3:0] {
		ST_IDLE, ST_RD, ST_SQ, ST_UPD, ST_DLD, ST_DIV, ST_MSQ, ST_SLD, ST_SQRT, ST_SPR, ST_BAND
	} state_t;

	state_t            state_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              out_free;

	assign in_stall = (state_q != ST_IDLE);
	assign out_free = !out_valid || !out_stall;

	always_comb begin
		cmd         = '0;
		cmd.load_in = (state_q == ST_IDLE) && in_valid;
		cmd.rd      = (state_q == ST_RD);
		cmd.sq      = (state_q == ST_SQ);
		cmd.upd     = (state_q == ST_UPD);
		cmd.dld     = (state_q == ST_DLD);
		cmd.div     = (state_q == ST_DIV);
		cmd.msq     = (state_q == ST_MSQ);
		cmd.sld     = (state_q == ST_SLD);
		cmd.sqrt    = (state_q == ST_SQRT);
		cmd.spr     = (state_q == ST_SPR);
		cmd.band    = (state_q == ST_BAND) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cnt_q     <= '0;
			out_valid <= 1'b0;
		end else begin
			if (cmd.band) begin
				out_valid <= 1'b1;
			end else if (out_valid && !out_stall) begin
				out_valid <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_RD;
					end
				end
				ST_RD:  state_q <= ST_SQ;
				ST_SQ:  state_q <= ST_UPD;
				ST_UPD: state_q <= ST_DLD;
				ST_DLD: begin
					cnt_q   <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == DIV_LAST) begin
						state_q <= ST_MSQ;
					end
				end
				ST_MSQ: state_q <= ST_SLD;
				ST_SLD: begin
					cnt_q   <= '0;
					state_q <= ST_SQRT;
				end
				ST_SQRT: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == SQRT_LAST) begin
						state_q <= ST_SPR;
					end
				end
				ST_SPR: state_q <= ST_BAND;
				ST_BAND: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ----- design/swbt_datapath.sv -----
// Datapath for the sliding window band tracker.
// Holds the sample ring, running sums, two parallel dividers, square root and band logic.
// Depends on swbt_pkg.
module swbt_datapath import swbt_pkg::*; #(
	parameter int unsigned MAX_WINDOW  = MAX_WINDOW_DEF,
	parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  swbt_cmd_t                cmd,
	input  logic                     cfg_wr,
	input  logic [CFG_IDX_W-1:0]     cfg_index,
	input  logic [CFG_DAT_W-1:0]     cfg_data,
	input  logic signed [DATA_W-1:0] sample,
	output logic signed [DATA_W-1:0] mean,
	output logic [SD_W-1:0]          std_dev,
	output logic signed [DATA_W-1:0] upper_band,
	output logic signed [DATA_W-1:0] lower_band,
	output logic                     window_full
);

	localparam int unsigned RING_AW  = $clog2(MAX_WINDOW);
	localparam int unsigned LEN_W    = $clog2(MAX_WINDOW + 1);
	localparam int unsigned SUM_W    = DATA_W + RING_AW + 1;
	localparam int unsigned SQSUM_W  = SQ_W + RING_AW;
	localparam int unsigned DIV_W    = SQSUM_W;

	logic [WLEN_W-1:0] wlen_q;
	logic [GAIN_W-1:0] gain_q;

	logic signed [SAMPLE_BITS-1:0] ring [MAX_WINDOW];
	logic signed [SAMPLE_BITS-1:0] old_q;
	logic signed [SAMPLE_BITS-1:0] samp_q;

	logic [RING_AW-1:0] wp_q;
	logic [LEN_W-1:0]   fill_q;
	logic signed [SUM_W-1:0] sum_q;
	logic [SQSUM_W-1:0]      sqsum_q;
	logic full_q;

	logic [SQ_W-1:0] sq_new_q;
	logic [SQ_W-1:0] sq_old_q;

	logic [DIV_W-1:0] div_a_q;
	logic [DIV_W-1:0] div_b_q;
	logic [LEN_W-1:0] rem_a_q;
	logic [LEN_W-1:0] rem_b_q;
	logic             neg_q;

	logic signed [DATA_W-1:0] mean_c;
	logic signed [DATA_W-1:0] mean_q;
	logic [SQ_W-1:0]          msq_q;
	logic [SD_W-1:0]          sd_q;
	logic                     wfull_q;

	logic [63:0] op_q;
	logic [33:0] srem_q;
	logic [31:0] root_q;

	logic [38:0] spread_q;

	logic [15:0]        wl_ext;
	logic [LEN_W-1:0]   len;
	logic [LEN_W:0]     wpx;
	logic [LEN_W:0]     lenx;
	logic [RING_AW-1:0] rd_idx;
	logic [RING_AW-1:0] wp_next;
	logic [SUM_W-1:0]   sum_mag;
	logic [LEN_W:0]     ta;
	logic [LEN_W:0]     tb;
	logic [32:0]        qa;
	logic [SQ_W-1:0]    msq_div;
	logic [36:0]        tsq;
	logic [SD_W-1:0]    sd;
	logic [46:0]        sprod;
	logic signed [40:0] m41;
	logic signed [40:0] sp41;

	always_comb begin
		wl_ext = 16'(wlen_q);
		if (wl_ext == 16'd0) begin
			len = LEN_W'(1);
		end else if (wl_ext > 16'(MAX_WINDOW)) begin
			len = LEN_W'(MAX_WINDOW);
		end else begin
			len = LEN_W'(wl_ext);
		end
		wpx  = (LEN_W+1)'(wp_q);
		lenx = (LEN_W+1)'(len);
		if (wpx >= lenx) begin
			rd_idx = RING_AW'(wpx - lenx);
		end else begin
			rd_idx = RING_AW'(wpx + (LEN_W+1)'(MAX_WINDOW) - lenx);
		end
		wp_next = (32'(wp_q) == MAX_WINDOW - 1) ? '0 : wp_q + 1'b1;
		sum_mag = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);
		ta = {rem_a_q, div_a_q[DIV_W-1]};
		tb = {rem_b_q, div_b_q[DIV_W-1]};
		qa = div_a_q[32:0];
		mean_c  = neg_q ? DATA_W'(-qa) : DATA_W'(qa);
		msq_div = div_b_q[SQ_W-1:0];
		tsq = {1'b0, srem_q, op_q[63:62]} - {3'b000, root_q, 2'b01};
		sd  = root_q[31] ? {SD_W{1'b1}} : root_q[SD_W-1:0];
		sprod = 47'(sd) * 47'(gain_q);
		m41  = 41'(mean_q);
		sp41 = $signed({2'b00, spread_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wlen_q  <= WLEN_RESET;
			gain_q  <= GAIN_RESET;
			wp_q    <= '0;
			fill_q  <= '0;
			sum_q   <= '0;
			sqsum_q <= '0;
		end else begin
			if (cfg_wr) begin
				unique case (cfg_index)
					REG_WINDOW_LENGTH: begin
						wlen_q  <= cfg_data[WLEN_W-1:0];
						wp_q    <= '0;
						fill_q  <= '0;
						sum_q   <= '0;
						sqsum_q <= '0;
					end
					REG_BAND_GAIN: gain_q <= cfg_data[GAIN_W-1:0];
					default: ;
				endcase
			end
			if (cmd.upd) begin
				sum_q <= sum_q + SUM_W'(samp_q)
					- (full_q ? SUM_W'(old_q) : SUM_W'(0));
				sqsum_q <= sqsum_q + SQSUM_W'(sq_new_q)
					- (full_q ? SQSUM_W'(sq_old_q) : SQSUM_W'(0));
				wp_q <= wp_next;
				if (!full_q) begin
					fill_q <= fill_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			samp_q <= sample[SAMPLE_BITS-1:0];
		end
		if (cmd.rd) begin
			old_q  <= ring[rd_idx];
			full_q <= (fill_q >= len);
		end
		if (cmd.sq) begin
			sq_new_q <= square_q16(33'(samp_q));
			sq_old_q <= square_q16(33'(old_q));
		end
		if (cmd.upd) begin
			ring[wp_q] <= samp_q;
		end
		if (cmd.dld) begin
			div_a_q <= DIV_W'(sum_mag);
			div_b_q <= DIV_W'(sqsum_q);
			rem_a_q <= '0;
			rem_b_q <= '0;
			neg_q   <= sum_q[SUM_W-1];
			wfull_q <= (fill_q == len);
		end
		if (cmd.div) begin
			if (ta >= {1'b0, fill_q}) begin
				rem_a_q <= LEN_W'(ta - {1'b0, fill_q});
				div_a_q <= {div_a_q[DIV_W-2:0], 1'b1};
			end else begin
				rem_a_q <= ta[LEN_W-1:0];
				div_a_q <= {div_a_q[DIV_W-2:0], 1'b0};
			end
			if (tb >= {1'b0, fill_q}) begin
				rem_b_q <= LEN_W'(tb - {1'b0, fill_q});
				div_b_q <= {div_b_q[DIV_W-2:0], 1'b1};
			end else begin
				rem_b_q <= tb[LEN_W-1:0];
				div_b_q <= {div_b_q[DIV_W-2:0], 1'b0};
			end
		end
		if (cmd.msq) begin
			mean_q <= mean_c;
			msq_q  <= square_q16(33'(mean_c));
		end
		if (cmd.sld) begin
			op_q   <= {1'b0, ((msq_div > msq_q) ? msq_div - msq_q : '0), 16'h0000};
			srem_q <= '0;
			root_q <= '0;
		end
		if (cmd.sqrt) begin
			op_q <= {op_q[61:0], 2'b00};
			if (!tsq[36]) begin
				srem_q <= tsq[33:0];
				root_q <= {root_q[30:0], 1'b1};
			end else begin
				srem_q <= {srem_q[31:0], op_q[63:62]};
				root_q <= {root_q[30:0], 1'b0};
			end
		end
		if (cmd.spr) begin
			sd_q     <= sd;
			spread_q <= sprod[46:8];
		end
		if (cmd.band) begin
			mean        <= mean_q;
			std_dev     <= sd_q;
			window_full <= wfull_q;
			upper_band  <= sat32(m41 + sp41);
			lower_band  <= sat32(m41 - sp41);
		end
	end

endmodule

// ----- design/sliding_window_band_tracker_top.sv -----
// Top level of the sliding window band tracker.
// Joins the controller and the datapath; depends on swbt_pkg, swbt_ctrl, swbt_datapath.
//
//   channel  direction  handshake              payload
//   input    in         in_valid / in_stall    sample
//   output   out        out_valid / out_stall  mean, std_dev, upper_band, lower_band, window_full
//   config   in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// Each sample runs to its band step before the next is taken: the two bit-serial dividers
// run side by side for SQ_W + clog2(MAX_WINDOW) steps and the square root runs 32 steps.
// Reset clears control and the window and sets the config registers to their defaults; no clearing pass is needed.
// A result waits in the output register under out_stall while the next item is taken.
module sliding_window_band_tracker_top import swbt_pkg::*; #(
	parameter int unsigned MAX_WINDOW  = MAX_WINDOW_DEF,
	parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic signed [DATA_W-1:0] sample,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic signed [DATA_W-1:0] mean,
	output logic [SD_W-1:0]          std_dev,
	output logic signed [DATA_W-1:0] upper_band,
	output logic signed [DATA_W-1:0] lower_band,
	output logic                     window_full,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [CFG_IDX_W-1:0]     cfg_index,
	input  logic [CFG_DAT_W-1:0]     cfg_data
);

	swbt_cmd_t cmd;

	assign cfg_ready = 1'b1;

	swbt_ctrl #(
		.MAX_WINDOW(MAX_WINDOW)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.cmd      (cmd)
	);

	swbt_datapath #(
		.MAX_WINDOW (MAX_WINDOW),
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.cfg_wr     (cfg_valid && cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.sample     (sample),
		.mean       (mean),
		.std_dev    (std_dev),
		.upper_band (upper_band),
		.lower_band (lower_band),
		.window_full(window_full)
	);

endmodule

// ----- tb/tb.sv -----
// Testbench for sliding_window_band_tracker_top: sends Q16.16 samples and checks
// each window mean, deviation and band against a predictor that keeps its own window.
// Depends on swbt_pkg and the design files.
module tb;
	import swbt_pkg::*;

	typedef struct {
		logic [DATA_W-1:0] mean;
		logic [SD_W-1:0]   sd;
		logic [DATA_W-1:0] upper;
		logic [DATA_W-1:0] lower;
		logic              full;
	} band_stats_t;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     in_valid = 1'b0;
	logic                     in_stall;
	logic signed [DATA_W-1:0] sample = '0;
	logic                     out_valid;
	logic                     out_stall = 1'b1;
	logic signed [DATA_W-1:0] mean;
	logic [SD_W-1:0]          std_dev;
	logic signed [DATA_W-1:0] upper_band;
	logic signed [DATA_W-1:0] lower_band;
	logic                     window_full;
	logic                     cfg_valid = 1'b0;
	logic                     cfg_ready;
	logic [CFG_IDX_W-1:0]     cfg_index = REG_WINDOW_LENGTH;
	logic [CFG_DAT_W-1:0]     cfg_data = '0;

	sliding_window_band_tracker_top u_dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	longint          win_ring [MAX_WINDOW_DEF];
	int unsigned     win_pos;
	int unsigned     win_fill;
	longint          win_sum;
	longint unsigned win_sqsum;
	int unsigned     win_len;
	longint unsigned gain_q;

	band_stats_t pending_stats[$];
	int          mismatches;
	bit          eager;
	int          freeze_cycles;
	int          idle_cycles;

	function automatic longint unsigned square_of(longint v);
		longint unsigned a;
		a = (v < 0) ? longint'(-v) : longint'(v);
		return (a * a) >> 16;
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned r;
		longint unsigned b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic logic [DATA_W-1:0] clamp32(longint v);
		if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
		if (v < -64'sd2147483648) return 32'h8000_0000;
		return v[DATA_W-1:0];
	endfunction

	function automatic band_stats_t next_band_stats(logic [DATA_W-1:0] raw);
		band_stats_t     r;
		longint          s;
		longint          old;
		longint          avg;
		int unsigned     len;
		longint unsigned msq;
		longint unsigned avg_sq;
		longint unsigned dev_var;
		longint unsigned sd;
		longint unsigned spread;
		s = longint'(signed'(raw));
		len = (win_len == 0) ? 1 : (win_len > MAX_WINDOW_DEF) ? MAX_WINDOW_DEF : win_len;
		if (win_fill >= len) begin
			old = win_ring[(win_pos + MAX_WINDOW_DEF - len) % MAX_WINDOW_DEF];
			win_sum -= old;
			win_sqsum -= square_of(old);
		end else begin
			win_fill++;
		end
		win_ring[win_pos] = s;
		win_sum += s;
		win_sqsum += square_of(s);
		win_pos = (win_pos + 1) % MAX_WINDOW_DEF;
		avg = win_sum / longint'(win_fill);
		msq = win_sqsum / longint'(win_fill);
		avg_sq = square_of(avg);
		dev_var = (msq > avg_sq) ? msq - avg_sq : 0;
		sd = int_sqrt(dev_var << 16);
		if (sd > 64'h7FFF_FFFF) sd = 64'h7FFF_FFFF;
		spread = (sd * gain_q) >> 8;
		r.mean = avg[DATA_W-1:0];
		r.sd = sd[SD_W-1:0];
		r.upper = clamp32(avg + longint'(spread));
		r.lower = clamp32(avg - longint'(spread));
		r.full = (win_fill == len);
		return r;
	endfunction

	function automatic int draw_gap();
		if (eager) return 0;
		if ($urandom_range(0, 3) == 0) return 0;
		return $urandom_range(0, 17);
	endfunction

	int hold_left;
	always @(posedge clk) begin
		band_stats_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_stats.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result mean=%h", mean);
			end else begin
				e = pending_stats.pop_front();
				if (mean !== e.mean || std_dev !== e.sd || upper_band !== e.upper ||
						lower_band !== e.lower || window_full !== e.full) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch exp %h %h %h %h %b got %h %h %h %h %b",
							e.mean, e.sd, e.upper, e.lower, e.full,
							mean, std_dev, upper_band, lower_band, window_full);
				end
			end
			hold_left = draw_gap();
		end
		if (freeze_cycles > 0) begin
			freeze_cycles--;
			out_stall <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= 3000) begin
			$display("[sliding_window_band_tracker_top] ERROR");
			$finish;
		end
	end

	task automatic send_sample(logic [DATA_W-1:0] s);
		int gap;
		gap = draw_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		sample <= s;
		do @(posedge clk); while (in_stall);
		pending_stats.insert(pending_stats.size(), next_band_stats(s));
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending_stats.size() != 0) @(posedge clk);
		repeat (120) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
		drain();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == REG_WINDOW_LENGTH) begin
			win_len = 32'(val[WLEN_W-1:0]);
			win_pos = 0;
			win_fill = 0;
			win_sum = 0;
			win_sqsum = 0;
		end else begin
			gain_q = 64'(val);
		end
	endtask

	function automatic logic [DATA_W-1:0] rand_sample(int level);
		case ($urandom_range(0, 5))
			0: return $urandom;
			1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
			default: return level + $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
		endcase
	endfunction

	task automatic test_directed();
		logic [DATA_W-1:0] edges [6] = '{32'h7FFF_FFFF, 32'h8000_0000, 0,
			32'hFFFF_FFFF, 1, 32'h0001_0000};
		foreach (edges[i]) send_sample(edges[i]);
		write_reg(REG_WINDOW_LENGTH, 16'd1);
		send_sample(32'h8000_0000);
		send_sample(32'h7FFF_FFFF);
		write_reg(REG_WINDOW_LENGTH, 16'd0);
		send_sample(32'h1234_5678);
		send_sample(32'hFEDC_BA98);
		write_reg(REG_BAND_GAIN, 16'hFFFF);
		write_reg(REG_WINDOW_LENGTH, 16'd2);
		send_sample(32'h7FFF_FFFF);
		send_sample(32'h8000_0000);
		send_sample(32'h7FFF_FFFF);
		write_reg(REG_BAND_GAIN, 16'd0);
		send_sample(32'h8000_0000);
		send_sample(32'h0000_1000);
		write_reg(REG_WINDOW_LENGTH, 16'd127);
		write_reg(REG_BAND_GAIN, 16'd100);
		repeat (4) send_sample($urandom);
	endtask

	task automatic test_random_windows();
		int level;
		int lens [8] = '{64, 1, 3, 100, 17, 64, 8, 40};
		for (int p = 0; p < 8; p++) begin
			write_reg(REG_WINDOW_LENGTH,
				CFG_DAT_W'((p < 6) ? lens[p] : $urandom_range(1, 64)));
			write_reg(REG_BAND_GAIN, CFG_DAT_W'((p == 2) ? 16'hFFFF : (p == 4) ? 16'd256 :
				$urandom_range(256, 65535)));
			eager = (p == 5);
			level = $urandom;
			repeat (150) send_sample(rand_sample(level));
			eager = 0;
		end
	endtask

	task automatic test_backpressure();
		freeze_cycles = 600;
		repeat (12) send_sample($urandom);
		drain();
		repeat (20) send_sample(rand_sample(0));
	endtask

	initial begin
		win_len = 32'(WLEN_RESET);
		gain_q = 64'(GAIN_RESET);
		win_pos = 0;
		win_fill = 0;
		win_sum = 0;
		win_sqsum = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_backpressure();
		test_random_windows();
		drain();
		if (mismatches == 0 && pending_stats.size() == 0)
			$display("[sliding_window_band_tracker_top] OK");
		else
			$display("[sliding_window_band_tracker_top] ERROR");
		$finish;
	end
endmodule

// ----- filelist.f -----
design/swbt_pkg.sv
design/swbt_ctrl.sv
design/swbt_datapath.sv
design/sliding_window_band_tracker_top.sv
tb/tb.sv
